@@ rtl/core/scs_pkg.sv @@
// ----------------------------------------------------------------------------
// Stratospheric column split: shared types and constants
// Field widths, status codes and the record handed from the front to the back.
// ----------------------------------------------------------------------------
package scs_pkg;

    localparam int unsigned MAX_LEVELS_DEF = 64;
    localparam int unsigned SUM_W          = 30;
    localparam int unsigned PRES_W         = 24;
    localparam int unsigned COEF_B_W       = 16;
    localparam int unsigned GAS_W          = 24;
    localparam int unsigned SLANT_W        = 32;
    localparam int unsigned AMF_W          = 16;
    localparam int unsigned THR_W          = 16;
    localparam int unsigned COL_W          = 32;
    localparam int unsigned STATUS_W       = 2;
    localparam int unsigned IN_DATA_W      = 176;
    localparam int unsigned IN_USER_W      = 2;
    localparam logic [THR_W-1:0] THR_RESET = 16'd4096;

    typedef enum logic [STATUS_W-1:0] {
        ST_VALID   = 2'd0,
        ST_SKIPPED = 2'd1,
        ST_OVER    = 2'd2,
        ST_NO_TROP = 2'd3
    } t_status;

    typedef struct packed {
        logic [SUM_W-1:0]          captured;
        logic                      found;
        logic                      skip;
        logic signed [SLANT_W-1:0] slant;
        logic [AMF_W-1:0]          amf_t;
        logic [AMF_W-1:0]          amf_s;
    } t_pixel;

endpackage

@@ rtl/core/scs_queue.sv @@
// ----------------------------------------------------------------------------
// Pixel queue
// Short register queue that decouples the level front end from the back end.
// ----------------------------------------------------------------------------
module scs_queue #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr, n_wr, r_rd, n_rd;
    logic [CW-1:0]    r_cnt, n_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

@@ rtl/core/scs_front.sv @@
// ----------------------------------------------------------------------------
// Level front end
// Accumulates partial columns, tests each level against the tropopause and
// hands one record per pixel to the queue.
// ----------------------------------------------------------------------------
module scs_front #(
    parameter int unsigned MAX_LEVELS = scs_pkg::MAX_LEVELS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic [scs_pkg::IN_DATA_W-1:0]     i_data,
    input  logic [scs_pkg::IN_USER_W-1:0]     i_user,
    input  logic                              i_last,
    output logic                              o_ready,
    input  logic                              i_q_full,
    output logic                              o_q_push,
    output scs_pkg::t_pixel                   o_q_data
);
    localparam int unsigned CNT_W = $clog2(MAX_LEVELS + 1);
    localparam int unsigned LHS_W = scs_pkg::PRES_W + scs_pkg::COEF_B_W + 1;

    logic [scs_pkg::PRES_W-1:0]    lvl_a, psurf, ptrop;
    logic [scs_pkg::COEF_B_W-1:0]  lvl_b;
    logic [scs_pkg::GAS_W-1:0]     gas;
    logic signed [scs_pkg::SLANT_W-1:0] slant;
    logic [scs_pkg::AMF_W-1:0]     amf_t, amf_s;
    logic [LHS_W-1:0]              lhs, rhs;
    logic [scs_pkg::SUM_W:0]       sum_ext;
    logic                          take, active, hit;

    logic [scs_pkg::SUM_W-1:0] r_run, n_run, r_cap, n_cap;
    logic                      r_found, n_found;
    logic [CNT_W-1:0]          r_cnt, n_cnt;

    assign lvl_a = i_data[23:0];
    assign lvl_b = i_data[39:24];
    assign gas   = i_data[63:40];
    assign psurf = i_data[87:64];
    assign ptrop = i_data[111:88];
    assign slant = i_data[143:112];
    assign amf_t = i_data[159:144];
    assign amf_s = i_data[175:160];

    assign o_ready = !i_q_full;
    assign take    = i_valid && o_ready;
    assign active  = (r_cnt < CNT_W'(MAX_LEVELS));
    assign lhs     = {2'b0, lvl_a, 15'd0} + LHS_W'(lvl_b * psurf);
    assign rhs     = {2'b0, ptrop, 15'd0};
    assign hit     = active && (lhs > rhs);
    assign sum_ext = {1'b0, r_run} + (scs_pkg::SUM_W + 1)'(gas);

    always_comb begin
        n_run   = r_run;
        n_cap   = r_cap;
        n_found = r_found;
        n_cnt   = r_cnt;
        if (take) begin
            if (hit) begin
                n_cap   = r_run;
                n_found = 1'b1;
            end
            if (active) begin
                n_run = sum_ext[scs_pkg::SUM_W] ? '1 : sum_ext[scs_pkg::SUM_W-1:0];
                n_cnt = r_cnt + 1'b1;
            end
            if (i_last) begin
                n_run   = '0;
                n_cap   = '0;
                n_found = 1'b0;
                n_cnt   = '0;
            end
        end
    end

    assign o_q_push          = take && i_last;
    assign o_q_data.captured = hit ? r_run : r_cap;
    assign o_q_data.found    = hit || r_found;
    assign o_q_data.skip     = i_user[0] || i_user[1] || slant[scs_pkg::SLANT_W-1];
    assign o_q_data.slant    = slant;
    assign o_q_data.amf_t    = amf_t;
    assign o_q_data.amf_s    = amf_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run   <= '0;
            r_cap   <= '0;
            r_found <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_run   <= n_run;
            r_cap   <= n_cap;
            r_found <= n_found;
            r_cnt   <= n_cnt;
        end
    end

endmodule

@@ rtl/core/scs_back.sv @@
// ----------------------------------------------------------------------------
// Column back end
// Threshold test, serial division and saturation for one pixel at a time.
// ----------------------------------------------------------------------------
module scs_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic [scs_pkg::THR_W-1:0]          i_thresh,
    input  logic                               i_q_empty,
    input  scs_pkg::t_pixel                    i_q_data,
    output logic                               o_q_pop,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [scs_pkg::COL_W-1:0]          o_col,
    output logic [scs_pkg::STATUS_W-1:0]       o_status
);
    localparam int unsigned NUM_W = 48;
    localparam int unsigned DC_W  = $clog2(NUM_W);
    localparam int unsigned TS_W  = scs_pkg::SUM_W + scs_pkg::AMF_W;
    localparam int unsigned RHS_W = scs_pkg::THR_W + scs_pkg::AMF_W;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MUL  = 6'b000010,
        S_CMP  = 6'b000100,
        S_DIV  = 6'b001000,
        S_FIN  = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    t_state                     r_state;
    scs_pkg::t_pixel            r_pix;
    logic [TS_W-1:0]            r_ts;
    logic [RHS_W-1:0]           r_rhs;
    logic [NUM_W-1:0]           r_quo;
    logic [scs_pkg::AMF_W-1:0]  r_rem;
    logic [DC_W-1:0]            r_dcnt;
    logic                       r_neg;
    logic [scs_pkg::COL_W-1:0]  r_res_col;
    scs_pkg::t_status           r_res_st;
    logic                       r_out_valid;
    logic [scs_pkg::COL_W-1:0]  r_out_col;
    scs_pkg::t_status           r_out_st;

    logic signed [NUM_W-1:0]    num;
    logic [NUM_W-1:0]           num_mag;
    logic [scs_pkg::AMF_W:0]    trial;
    logic                       fits;
    logic                       out_free;

    assign num      = $signed({{(NUM_W-scs_pkg::SLANT_W-12){r_pix.slant[scs_pkg::SLANT_W-1]}},
                               r_pix.slant, 12'd0}) - $signed({2'b0, r_ts});
    assign num_mag  = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    assign trial    = {r_rem, r_quo[NUM_W-1]};
    assign fits     = (trial >= {1'b0, r_pix.amf_s});
    assign out_free = !r_out_valid || i_ready;
    assign o_q_pop  = (r_state == S_IDLE) && !i_q_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: if (!i_q_empty) r_state <= S_MUL;
                S_MUL:  r_state <= S_CMP;
                S_CMP: begin
                    if (!r_pix.skip && r_pix.found && ({r_ts, 12'd0} < 58'(r_rhs))) begin
                        r_state <= S_DIV;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_DIV:  if (r_dcnt == '0) r_state <= S_FIN;
                S_FIN:  r_state <= S_OUT;
                S_OUT:  if (out_free) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: r_pix <= i_q_data;
            S_MUL: begin
                r_ts  <= r_pix.captured * r_pix.amf_t;
                r_rhs <= i_thresh * r_pix.amf_s;
            end
            S_CMP: begin
                r_res_col <= '0;
                r_neg     <= num[NUM_W-1];
                r_quo     <= num_mag;
                r_rem     <= '0;
                r_dcnt    <= DC_W'(NUM_W - 1);
                if (r_pix.skip) begin
                    r_res_st <= scs_pkg::ST_SKIPPED;
                end else if (!r_pix.found) begin
                    r_res_st <= scs_pkg::ST_NO_TROP;
                end else if ({r_ts, 12'd0} < 58'(r_rhs)) begin
                    r_res_st <= scs_pkg::ST_VALID;
                end else begin
                    r_res_st <= scs_pkg::ST_OVER;
                end
            end
            S_DIV: begin
                r_rem  <= fits ? scs_pkg::AMF_W'(trial - {1'b0, r_pix.amf_s})
                               : scs_pkg::AMF_W'(trial);
                r_quo  <= {r_quo[NUM_W-2:0], fits};
                r_dcnt <= r_dcnt - 1'b1;
            end
            S_FIN: begin
                if (!r_neg && (r_quo > NUM_W'(32'h7FFF_FFFF))) begin
                    r_res_col <= 32'h7FFF_FFFF;
                end else if (r_neg && (r_quo > NUM_W'(33'h0_8000_0000))) begin
                    r_res_col <= 32'h8000_0000;
                end else begin
                    r_res_col <= r_neg ? 32'(-r_quo) : r_quo[scs_pkg::COL_W-1:0];
                end
            end
            S_OUT: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_OUT) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_OUT) && out_free) begin
            r_out_col <= r_res_col;
            r_out_st  <= r_res_st;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_col    = r_out_col;
    assign o_status = r_out_st;

    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state)) else $error("back end state not one-hot");
    a_zero_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out_st != scs_pkg::ST_VALID) |-> r_out_col == '0)
        else $error("column not zero on a status result");
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> r_pix.amf_s != '0)
        else $error("division by a zero air mass factor");

endmodule

@@ rtl/core/strat_column_split.sv @@
// ----------------------------------------------------------------------------
// Stratospheric column split
// Splits a pixel's slant column into its stratospheric part from level items.
// ----------------------------------------------------------------------------
// Channel      | Direction | Contents
// s_axis       | in        | one level item per request, tlast on the top level
// m_axis       | out       | one result per pixel: column and status
// cfg          | in        | trop_threshold write
//
// Level items are taken at one per cycle while the pixel queue has room.
// Each pixel's result is worked out in the back end by a 48-step divider that
// yields one quotient bit per cycle, and only for pixels that pass the threshold;
// the back end takes a new pixel only once the last one is through. Reset is
// synchronous and clears all control state at once. A stalled output holds the
// back end, and a full queue stalls the input.
module strat_column_split #(
    parameter int unsigned MAX_LEVELS = scs_pkg::MAX_LEVELS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // level_a, level_b, gas_partial, psurf, ptrop, slant, amf_trop, amf_strat
    input  logic [scs_pkg::IN_DATA_W-1:0]     i_s_axis_tdata,
    // quality_nonzero, input_invalid
    input  logic [scs_pkg::IN_USER_W-1:0]     i_s_axis_tuser,
    input  logic                              i_s_axis_tlast,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // strat_column
    output logic [scs_pkg::COL_W-1:0]         o_m_axis_tdata,
    // split_status
    output logic [scs_pkg::STATUS_W-1:0]      o_m_axis_tuser,
    input  logic                              i_cfg_wr_en,
    input  logic [scs_pkg::THR_W-1:0]         i_cfg_wr_data
);
    logic [scs_pkg::THR_W-1:0] r_thresh;
    logic                      q_full, q_empty, q_push, q_pop;
    scs_pkg::t_pixel           q_in, q_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= scs_pkg::THR_RESET;
        end else if (i_cfg_wr_en) begin
            r_thresh <= i_cfg_wr_data;
        end
    end

    scs_front #(.MAX_LEVELS(MAX_LEVELS)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_axis_tvalid),
        .i_data   (i_s_axis_tdata),
        .i_user   (i_s_axis_tuser),
        .i_last   (i_s_axis_tlast),
        .o_ready  (o_s_axis_tready),
        .i_q_full (q_full),
        .o_q_push (q_push),
        .o_q_data (q_in)
    );

    scs_queue #(.WIDTH($bits(scs_pkg::t_pixel)), .DEPTH(2)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_empty (q_empty)
    );

    scs_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_thresh  (r_thresh),
        .i_q_empty (q_empty),
        .i_q_data  (q_out),
        .o_q_pop   (q_pop),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_col     (o_m_axis_tdata),
        .o_status  (o_m_axis_tuser)
    );

endmodule

@@ sim/strat_column_split_test.sv @@
// ----------------------------------------------------------------------------
// Stratospheric column split testbench
// Streams pixels of level items into the block under random source and sink
// gaps, predicts each pixel's column and status, and compares every result.
// ----------------------------------------------------------------------------
module strat_column_split_test;

    localparam int unsigned LEVEL_LIMIT = scs_pkg::MAX_LEVELS_DEF;
    localparam longint unsigned SUM_SAT = 64'h3FFF_FFFF;
    localparam longint unsigned CYCLE_LIMIT = 2_000_000;

    typedef struct {
        logic [23:0] level_a;
        logic [15:0] level_b;
        logic [23:0] gas;
        logic [23:0] psurf;
        logic [23:0] ptrop;
        logic signed [31:0] slant;
        logic [15:0] amf_t;
        logic [15:0] amf_s;
        logic badq;
        logic invalid;
        logic last;
    } t_level;

    typedef struct {
        logic [31:0] column;
        scs_pkg::t_status status;
    } t_split;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_s_axis_tvalid = 1'b0;
    logic o_s_axis_tready;
    logic [scs_pkg::IN_DATA_W-1:0] i_s_axis_tdata = '0;
    logic [scs_pkg::IN_USER_W-1:0] i_s_axis_tuser = '0;
    logic i_s_axis_tlast = 1'b0;
    logic o_m_axis_tvalid;
    logic i_m_axis_tready = 1'b0;
    logic [scs_pkg::COL_W-1:0] o_m_axis_tdata;
    logic [scs_pkg::STATUS_W-1:0] o_m_axis_tuser;
    logic i_cfg_wr_en = 1'b0;
    logic [scs_pkg::THR_W-1:0] i_cfg_wr_data = '0;

    strat_column_split DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid), .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata(i_s_axis_tdata), .i_s_axis_tuser(i_s_axis_tuser),
        .i_s_axis_tlast(i_s_axis_tlast),
        .o_m_axis_tvalid(o_m_axis_tvalid), .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata(o_m_axis_tdata), .o_m_axis_tuser(o_m_axis_tuser),
        .i_cfg_wr_en(i_cfg_wr_en), .i_cfg_wr_data(i_cfg_wr_data)
    );

    always #2 i_clk = ~i_clk;

    logic [15:0] threshold = scs_pkg::THR_RESET;
    longint unsigned level_sum, capture_sum;
    bit level_seen;
    int unsigned level_count;
    t_split pending_splits[$];
    int unsigned error_count = 0;
    longint unsigned cycle_count = 0;
    bit hold_sink = 1'b0;

    function automatic t_split split_level(t_level lv);
        t_split r;
        longint unsigned lhs, ts;
        longint signed num, q;
        r.column = '0;
        r.status = scs_pkg::ST_VALID;
        if (level_count < LEVEL_LIMIT) begin
            lhs = (longint'(lv.level_a) << 15) + longint'(lv.level_b) * longint'(lv.psurf);
            if (lhs > (longint'(lv.ptrop) << 15)) begin
                capture_sum = level_sum;
                level_seen = 1'b1;
            end
            level_sum += lv.gas;
            if (level_sum > SUM_SAT) level_sum = SUM_SAT;
            level_count++;
        end
        if (lv.badq || lv.invalid || lv.slant < 0) begin
            r.status = scs_pkg::ST_SKIPPED;
        end else if (!level_seen) begin
            r.status = scs_pkg::ST_NO_TROP;
        end else begin
            ts = capture_sum * lv.amf_t;
            if ((ts << 12) < longint'(threshold) * longint'(lv.amf_s)) begin
                num = longint'(lv.slant) * 4096 - longint'(ts);
                q = num / longint'(lv.amf_s);
                if (q > 64'sd2147483647) q = 64'sd2147483647;
                if (q < -64'sd2147483648) q = -64'sd2147483648;
                r.column = q[31:0];
            end else begin
                r.status = scs_pkg::ST_OVER;
            end
        end
        return r;
    endfunction

    task automatic gap(input int unsigned chance);
        int unsigned n;
        if ($urandom_range(99) < chance) begin
            n = ($urandom_range(9) == 0) ? $urandom_range(40, 10) : $urandom_range(3, 1);
            i_s_axis_tvalid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    int unsigned src_gap = 30;

    task automatic send_level(t_level lv);
        t_split r;
        gap(src_gap);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= {lv.amf_s, lv.amf_t, lv.slant, lv.ptrop, lv.psurf, lv.gas,
                           lv.level_b, lv.level_a};
        i_s_axis_tuser <= {lv.invalid, lv.badq};
        i_s_axis_tlast <= lv.last;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        r = split_level(lv);
        if (lv.last) begin
            pending_splits.push_back(r);
            level_sum = 0;
            capture_sum = 0;
            level_seen = 1'b0;
            level_count = 0;
        end
    endtask

    function automatic logic [31:0] rand_wide();
        case ($urandom_range(3))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Pixel with random content and a random tropopause pressure.
    task automatic send_pixel(int unsigned levels, bit wild);
        t_level lv;
        logic [23:0] psurf, ptrop;
        logic signed [31:0] slant;
        logic [15:0] amf_t, amf_s;
        bit badq, invalid;
        psurf = 24'(wild ? rand_wide() : $urandom_range(110000, 50000));
        ptrop = 24'(wild ? rand_wide() : $urandom_range(40000, 5000));
        slant = ($urandom_range(7) == 0) ? $urandom : $urandom_range(2000000, 0);
        amf_t = 16'(wild ? rand_wide() : $urandom_range(12000, 2000));
        amf_s = ($urandom_range(15) == 0) ? 16'd0
              : 16'(wild ? rand_wide() : $urandom_range(16000, 2000));
        badq = ($urandom_range(9) == 0);
        invalid = ($urandom_range(9) == 0);
        for (int unsigned i = 0; i < levels; i++) begin
            lv.level_a = 24'(wild ? rand_wide() : $urandom_range(6000, 0) * (levels - i));
            lv.level_b = 16'(wild ? rand_wide()
                                  : $urandom_range(32768) * (levels - i) / levels);
            lv.gas = 24'(wild ? rand_wide() : $urandom_range(5000));
            lv.psurf = psurf;
            lv.ptrop = ptrop;
            lv.last = (i == levels - 1);
            lv.slant = lv.last ? slant : $urandom;
            lv.amf_t = lv.last ? amf_t : 16'($urandom);
            lv.amf_s = lv.last ? amf_s : 16'($urandom);
            lv.badq = lv.last ? badq : 1'($urandom_range(1));
            lv.invalid = lv.last ? invalid : 1'($urandom_range(1));
            send_level(lv);
        end
    endtask

    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        while (pending_splits.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic write_threshold(logic [15:0] value);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        threshold = value;
    endtask

    task automatic test_directed();
        t_level lv;
        lv = '{24'hFFFFFF, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'h0,
               32'sh7FFFFFFF, 16'h0001, 16'h0001, 1'b0, 1'b0, 1'b0};
        send_level(lv);
        lv.last = 1'b1;
        send_level(lv);
        lv.slant = -32'sd1;
        send_level(lv);
        lv.slant = 32'sd100; lv.badq = 1'b1;
        send_level(lv);
        lv.badq = 1'b0; lv.invalid = 1'b1;
        send_level(lv);
        lv = '{24'h0, 16'h0, 24'h0, 24'h0, 24'hFFFFFF, 32'sd5, 16'hFFFF, 16'hFFFF,
               1'b0, 1'b0, 1'b1};
        send_level(lv);
        lv = '{24'd20000, 16'd32768, 24'd1000, 24'd100000, 24'd10000, 32'sd0, 16'd4096,
               16'd0, 1'b0, 1'b0, 1'b0};
        send_level(lv);
        lv.level_b = 16'hFFFF; send_level(lv);
        lv.last = 1'b1; send_level(lv);
        lv.slant = 32'sd0; lv.amf_s = 16'hFFFF; lv.amf_t = 16'h0; lv.gas = 24'h0;
        send_level(lv);
        drain();
    endtask

    task automatic test_level_overflow();
        send_pixel(LEVEL_LIMIT + 5, 1'b0);
        send_pixel(LEVEL_LIMIT, 1'b1);
        send_pixel(1, 1'b0);
        drain();
    endtask

    task automatic test_thresholds();
        logic [15:0] settings[5] = '{16'd0, 16'hFFFF, 16'd1, 16'd4096, 16'd40000};
        foreach (settings[k]) begin
            write_threshold(settings[k]);
            repeat (12) send_pixel($urandom_range(8, 2), $urandom_range(3) == 0);
            drain();
        end
    endtask

    task automatic test_backpressure();
        hold_sink = 1'b1;
        src_gap = 0;
        repeat (20) send_pixel($urandom_range(4, 1), 1'b0);
        src_gap = 30;
        drain();
    endtask

    task automatic test_random();
        int unsigned sent = 0;
        int unsigned n;
        while (sent < 1250) begin
            if (sent % 500 == 0) begin
                drain();
                write_threshold(16'($urandom));
            end
            n = ($urandom_range(19) == 0) ? $urandom_range(70, 20) : $urandom_range(10, 1);
            send_pixel(n, $urandom_range(4) == 0);
            sent += n;
        end
        drain();
    endtask

    // Sink: random gaps, with one long hold requested by the backpressure test.
    initial begin
        int unsigned n;
        forever begin
            if (hold_sink) begin
                i_m_axis_tready <= 1'b0;
                repeat (600) @(posedge i_clk);
                hold_sink = 1'b0;
            end
            if ($urandom_range(99) < 30) begin
                i_m_axis_tready <= 1'b0;
                n = ($urandom_range(9) == 0) ? $urandom_range(60, 10) : $urandom_range(3, 1);
                repeat (n) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        t_split want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_splits.size() == 0) begin
                $display("%0t unexpected result column %0d status %0d", $time,
                         $signed(o_m_axis_tdata), o_m_axis_tuser);
                error_count++;
            end else begin
                want = pending_splits.pop_front();
                if (o_m_axis_tdata !== want.column) begin
                    $display("%0t column expected %0d actual %0d", $time,
                             $signed(want.column), $signed(o_m_axis_tdata));
                    error_count++;
                end
                if (o_m_axis_tuser !== want.status) begin
                    $display("%0t status expected %0d actual %0d", $time,
                             want.status, o_m_axis_tuser);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("strat_column_split verification failed");
            $finish;
        end
    end

    initial begin
        level_sum = 0;
        capture_sum = 0;
        level_seen = 1'b0;
        level_count = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_level_overflow();
        test_thresholds();
        test_backpressure();
        test_random();
        if (error_count == 0 && pending_splits.size() == 0) begin
            $display("strat_column_split verification clean");
        end else begin
            $display("strat_column_split verification failed");
        end
        $finish;
    end
endmodule

@@ strat_column_split.f @@
rtl/core/scs_pkg.sv
rtl/core/scs_queue.sv
rtl/core/scs_front.sv
rtl/core/scs_back.sv
rtl/core/strat_column_split.sv
sim/strat_column_split_test.sv
